@@ rtl/core/tsop_pkg.sv @@
// Shared types, telnet byte codes and reply-burst tables for the telnet option parser.
package tsop_pkg;

  // Telnet command bytes.
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] TN_NOP_LO = 8'd240;
  localparam logic [7:0] TN_NOP_HI = 8'd249;
  localparam logic [7:0] TN_SB_SEND = 8'd1;

  // Option numbers.
  localparam logic [7:0] OPT_ECHO     = 8'd1;
  localparam logic [7:0] OPT_SGA      = 8'd3;
  localparam logic [7:0] OPT_TTYPE    = 8'd24;
  localparam logic [7:0] OPT_TSPEED   = 8'd32;
  localparam logic [7:0] OPT_LINEMODE = 8'd34;
  localparam logic [7:0] OPT_MCCP2    = 8'd86;
  localparam logic [7:0] OPT_MCCP3    = 8'd87;
  localparam logic [7:0] OPT_MAX      = 8'd140;

  // Characters of the speed report text.
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_NUL   = 8'd0;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  // Flag bit positions.
  localparam int FLAG_ECHO  = 0;
  localparam int FLAG_SGA   = 1;
  localparam int FLAG_MCCP2 = 2;
  localparam int FLAG_MCCP3 = 3;

  // Burst codes carried from the parser to the emitter.
  localparam logic [2:0] BURST_STATUS  = 3'd0;
  localparam logic [2:0] BURST_CHAR    = 3'd1;
  localparam logic [2:0] BURST_PRE     = 3'd2;
  localparam logic [2:0] BURST_SUBSEND = 3'd3;
  localparam logic [2:0] BURST_SUB86   = 3'd4;
  localparam logic [2:0] BURST_REFUSE  = 3'd5;

  localparam int QUEUE_DEPTH = 4;

  typedef logic [4:0] step_t;

  typedef struct packed {
    logic [2:0]  burst;
    logic [7:0]  data;
    logic [7:0]  aux;
    logic        in_command;
    logic        error;
    logic [3:0]  flags;
    logic [15:0] tx_speed;
    logic [15:0] rx_speed;
  } job_t;

  // Index of the final beat of each burst.
  function automatic step_t burst_last(input logic [2:0] burst);
    step_t n;
    case (burst)
      BURST_PRE:     n = 5'd17;
      BURST_SUBSEND: n = 5'd5;
      BURST_SUB86:   n = 5'd4;
      BURST_REFUSE:  n = 5'd2;
      default:       n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] preamble_byte(input step_t step);
    logic [7:0] b;
    case (step)
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15: b = TN_IAC;
      5'd1, 5'd4:   b = TN_DO;
      5'd2:         b = OPT_TSPEED;
      5'd5:         b = OPT_TTYPE;
      5'd7, 5'd10:  b = TN_WONT;
      5'd8:         b = OPT_ECHO;
      5'd11:        b = OPT_SGA;
      5'd13, 5'd16: b = TN_WILL;
      5'd14:        b = OPT_MCCP2;
      5'd17:        b = OPT_MCCP3;
      default:      b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] burst_byte(input logic [2:0] burst, input logic [7:0] data,
                                            input logic [7:0] aux, input step_t step);
    logic [7:0] b;
    b = 8'd0;
    case (burst)
      BURST_CHAR: b = data;
      BURST_PRE:  b = preamble_byte(step);
      BURST_SUBSEND: begin
        case (step)
          5'd0:    b = TN_IAC;
          5'd1:    b = TN_SB;
          5'd2:    b = data;
          5'd3:    b = TN_SB_SEND;
          5'd4:    b = TN_IAC;
          default: b = TN_SE;
        endcase
      end
      BURST_SUB86: begin
        case (step)
          5'd0:    b = TN_IAC;
          5'd1:    b = TN_SB;
          5'd2:    b = data;
          5'd3:    b = TN_IAC;
          default: b = TN_SE;
        endcase
      end
      BURST_REFUSE: begin
        case (step)
          5'd0:    b = TN_IAC;
          5'd1:    b = aux;
          default: b = data;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] burst_kind(input logic [2:0] burst);
    logic [1:0] k;
    case (burst)
      BURST_STATUS: k = KIND_STATUS;
      BURST_CHAR:   k = KIND_CHAR;
      default:      k = KIND_REPLY;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/telnet_stream_option_parser_top.sv @@
// Top level of the telnet option parser: parser front end, job queue and beat emitter.
// An accepted beat's job passes the queue and is then loaded into the output register that
// raises m_tvalid with the job's first result beat.
// Throughput: one input beat per cycle while the queue has room; each input yields 1 to 18
// result beats, one per cycle while m_tready allows, so the emitter rate sets the sustained pace.
// Reset (rst, synchronous, active high) returns the parser to plain input, clears flags,
// speeds and the queue, and drops m_tvalid.
module telnet_stream_option_parser_top #(
  parameter int SUB_LIMIT    = 64,
  parameter int SPEED_WINDOW = 41
) (
  input  logic        clk,
  input  logic        rst,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], line_buffer_full[8], zero padding [15:9]
  input  logic        s_tuser,   // cmd: 0 received byte, 1 connection start
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_byte[7:0], in_command[8], error[9], echo_on[10],
                                 // sga_on[11], mccp2_on[12], mccp3_on[13], tx_speed[29:14],
                                 // rx_speed[45:30], zero padding [47:46]
  output logic [1:0]  m_tuser,   // kind: 0 status, 1 character, 2 reply byte
  output logic        m_tlast    // last result beat caused by one input beat
);
  import tsop_pkg::*;

  logic accept;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t new_job;
  job_t head_job;

  // The front end advances its state only on an accepted beat; the queue absorbs bursts
  // so the parser keeps taking bytes while the emitter is still sending a reply.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  tsop_front #(
    .SUB_LIMIT    (SUB_LIMIT),
    .SPEED_WINDOW (SPEED_WINDOW)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .start            (s_tuser),
    .rx_byte          (s_tdata[7:0]),
    .line_buffer_full (s_tdata[8]),
    .job              (new_job)
  );

  tsop_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (new_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  // The emitter walks the head job one beat per unstalled cycle and pops it with its last beat.
  tsop_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_job),
    .empty    (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/core/tsop_front.sv @@
// Front end: telnet parser state machine that turns each accepted beat into one burst job.
module tsop_front #(
  parameter int SUB_LIMIT    = 64,
  parameter int SPEED_WINDOW = 41
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            start,
  input  logic [7:0]      rx_byte,
  input  logic            line_buffer_full,
  output tsop_pkg::job_t  job
);
  import tsop_pkg::*;

  localparam int CW      = $clog2(SUB_LIMIT + 1);
  localparam int WIN_END = SPEED_WINDOW + 2;

  localparam logic [2:0] ST_INPUT = 3'd0;
  localparam logic [2:0] ST_IAC   = 3'd1;
  localparam logic [2:0] ST_CMD   = 3'd2;
  localparam logic [2:0] ST_SB    = 3'd3;
  localparam logic [2:0] ST_SE    = 3'd4;
  localparam logic [2:0] ST_ERROR = 3'd5;

  logic [2:0]    state, state_next;
  logic [7:0]    prev_byte, prev_byte_next;
  logic [CW-1:0] sub_count, sub_count_next;
  logic [7:0]    sub_option, sub_option_next;
  logic          comma_seen, comma_seen_next;
  logic          window_ended, window_ended_next;
  logic [15:0]   tx_accum, tx_accum_next;
  logic [15:0]   rx_accum, rx_accum_next;
  logic          tx_open, tx_open_next;
  logic          rx_open, rx_open_next;
  logic [3:0]    flags, flags_next;
  logic [15:0]   tx_speed, tx_speed_next;
  logic [15:0]   rx_speed, rx_speed_next;

  logic          is_digit;
  logic          in_window;
  logic [15:0]   digit_val;

  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [15:0] d);
    return 16'((acc << 3) + (acc << 1) + d);
  endfunction

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_val = {8'd0, 8'(rx_byte - CH_ZERO)};
  assign in_window = (32'(sub_count) >= 2) && (32'(sub_count) < WIN_END) && !window_ended;

  always_comb begin
    state_next        = state;
    prev_byte_next    = prev_byte;
    sub_count_next    = sub_count;
    sub_option_next   = sub_option;
    comma_seen_next   = comma_seen;
    window_ended_next = window_ended;
    tx_accum_next     = tx_accum;
    rx_accum_next     = rx_accum;
    tx_open_next      = tx_open;
    rx_open_next      = rx_open;
    flags_next        = flags;
    tx_speed_next     = tx_speed;
    rx_speed_next     = rx_speed;
    job               = '0;
    job.burst         = BURST_STATUS;

    if (start) begin
      job.burst = BURST_PRE;
    end else begin
      prev_byte_next = rx_byte;
      case (state)
        ST_INPUT: begin
          if (rx_byte == TN_IAC) begin
            state_next = ST_IAC;
          end else if (line_buffer_full) begin
            state_next = ST_ERROR;
          end else begin
            job.burst = BURST_CHAR;
            job.data  = rx_byte;
          end
        end
        ST_IAC: begin
          if (rx_byte == TN_SB) begin
            sub_count_next    = '0;
            sub_option_next   = 8'd0;
            comma_seen_next   = 1'b0;
            window_ended_next = 1'b0;
            tx_accum_next     = 16'd0;
            rx_accum_next     = 16'd0;
            tx_open_next      = 1'b1;
            rx_open_next      = 1'b1;
            state_next        = ST_SB;
          end else if (rx_byte inside {[TN_NOP_LO:TN_NOP_HI]}) begin
            state_next = ST_INPUT;
          end else begin
            state_next = ST_CMD;
          end
        end
        ST_SB: begin
          if (rx_byte == TN_IAC) begin
            state_next = ST_SE;
          end else if (32'(sub_count) >= SUB_LIMIT) begin
            state_next = ST_ERROR;
          end else begin
            sub_count_next = CW'(sub_count + 1'b1);
            if (sub_count == '0) begin
              sub_option_next = rx_byte;
            end else if (in_window) begin
              if (rx_byte == CH_NUL) begin
                window_ended_next = 1'b1;
              end else if (!comma_seen) begin
                if (rx_byte == CH_COMMA) begin
                  comma_seen_next = 1'b1;
                  tx_open_next    = 1'b0;
                end else if (tx_open && is_digit) begin
                  tx_accum_next = add_digit(tx_accum, digit_val);
                end else begin
                  tx_open_next = 1'b0;
                end
              end else if (rx_open && is_digit) begin
                rx_accum_next = add_digit(rx_accum, digit_val);
              end else begin
                rx_open_next = 1'b0;
              end
            end
          end
        end
        ST_SE: begin
          if (rx_byte == TN_SE) begin
            if (sub_count != '0) begin
              if (sub_option == OPT_TSPEED && comma_seen) begin
                tx_speed_next = tx_accum;
                rx_speed_next = rx_accum;
              end else if (sub_option == OPT_MCCP3) begin
                flags_next[FLAG_MCCP3] = 1'b1;
              end
            end
            state_next = ST_INPUT;
          end else begin
            state_next = ST_ERROR;
          end
        end
        ST_CMD: begin
          if (rx_byte <= OPT_MAX) begin
            state_next = ST_INPUT;
            case (rx_byte)
              OPT_TSPEED, OPT_TTYPE: begin
                job.burst = BURST_SUBSEND;
                job.data  = rx_byte;
              end
              OPT_MCCP2: begin
                if (prev_byte == TN_DO) begin
                  flags_next[FLAG_MCCP2] = 1'b1;
                  job.burst = BURST_SUB86;
                  job.data  = rx_byte;
                end
              end
              OPT_MCCP3, OPT_LINEMODE: ;
              OPT_ECHO: begin
                if (prev_byte == TN_DO) flags_next[FLAG_ECHO] = 1'b1;
              end
              OPT_SGA: begin
                if (prev_byte == TN_DO) begin
                  flags_next[FLAG_SGA] = 1'b1;
                end else if (prev_byte == TN_DONT) begin
                  flags_next[FLAG_SGA] = 1'b0;
                end
              end
              default: begin
                if (prev_byte == TN_DO || prev_byte == TN_WILL) begin
                  job.burst = BURST_REFUSE;
                  job.data  = rx_byte;
                  job.aux   = (prev_byte == TN_DO) ? TN_WONT : TN_DONT;
                end
              end
            endcase
          end else begin
            state_next = ST_ERROR;
          end
        end
        default: ;
      endcase
    end

    job.in_command = (state_next != ST_INPUT);
    job.error      = (state_next == ST_ERROR);
    job.flags      = flags_next;
    job.tx_speed   = tx_speed_next;
    job.rx_speed   = rx_speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INPUT;
      prev_byte    <= 8'd0;
      sub_count    <= '0;
      sub_option   <= 8'd0;
      comma_seen   <= 1'b0;
      window_ended <= 1'b0;
      tx_accum     <= 16'd0;
      rx_accum     <= 16'd0;
      tx_open      <= 1'b1;
      rx_open      <= 1'b1;
      flags        <= 4'd0;
      tx_speed     <= 16'd0;
      rx_speed     <= 16'd0;
    end else if (accept) begin
      state        <= state_next;
      prev_byte    <= prev_byte_next;
      sub_count    <= sub_count_next;
      sub_option   <= sub_option_next;
      comma_seen   <= comma_seen_next;
      window_ended <= window_ended_next;
      tx_accum     <= tx_accum_next;
      rx_accum     <= rx_accum_next;
      tx_open      <= tx_open_next;
      rx_open      <= rx_open_next;
      flags        <= flags_next;
      tx_speed     <= tx_speed_next;
      rx_speed     <= rx_speed_next;
    end
  end

endmodule

@@ rtl/core/tsop_queue.sv @@
// Small job queue between the parser and the beat emitter.
module tsop_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsop_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output tsop_pkg::job_t dout,
  output logic           empty
);
  import tsop_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (32'(count) == QUEUE_DEPTH);
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= AW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= AW'(rd_ptr + 1'b1);
      case ({push, pop})
        2'b10:   count <= (AW + 1)'(count + 1'b1);
        2'b01:   count <= (AW + 1)'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/tsop_back.sv @@
// Back end: expands the job at the queue head into result beats behind an output register.
module tsop_back (
  input  logic           clk,
  input  logic           rst,
  input  tsop_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);
  import tsop_pkg::*;

  step_t step;
  logic  load;
  logic  at_end;

  assign load   = !empty && (!m_tvalid || m_tready);
  assign at_end = (step == burst_last(head.burst));
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        step     <= at_end ? '0 : 5'(step + 1'b1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tuser <= burst_kind(head.burst);
      m_tlast <= at_end;
      m_tdata <= {2'b00, head.rx_speed, head.tx_speed, head.flags, head.error,
                  head.in_command, burst_byte(head.burst, head.data, head.aux, step)};
    end
  end

endmodule

@@ rtl/core/tsop_checker.sv @@
// Port-level checks on the result stream of the telnet option parser, bound to the top level.
module tsop_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // The error state is sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |=> !m_tvalid || m_tdata[9])
    else $error("error flag dropped without reset");

  // Error is a non-input parser state.
  a_err_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[9] || m_tdata[8])
    else $error("error shown outside command state");

  // Kind three is never produced, and a status beat carries a zero byte and ends its run.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3 && (m_tuser != 2'd0 || (m_tdata[7:0] == 8'd0 && m_tlast)))
    else $error("bad result kind or status beat");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat valid after reset");

endmodule

bind telnet_stream_option_parser_top tsop_checker u_tsop_checker (.*);

@@ tb/telnet_parser_checker.sv @@
// Checker for the telnet option parser: predicts every result beat and compares it.
module telnet_parser_checker #(
  parameter int SUB_LIMIT    = 64,
  parameter int SPEED_WINDOW = 41
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], line_buffer_full[8], zero padding [15:9]
  input  logic        s_tuser,   // cmd: 0 received byte, 1 connection start
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // out_byte[7:0], in_command[8], error[9], echo_on[10],
                                 // sga_on[11], mccp2_on[12], mccp3_on[13], tx_speed[29:14],
                                 // rx_speed[45:30], zero padding [47:46]
  input  logic [1:0]  m_tuser,   // kind: 0 status, 1 character, 2 reply byte
  input  logic        m_tlast,
  output int          fail_count,
  output int          awaited_count,
  output int          bytes_in,
  output int          beats_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import tsop_pkg::*;

  localparam int MAX_REPORTS = 10;

  // Connection-start preamble, first byte in the lowest bits.
  localparam logic [143:0] CONN_PREAMBLE = {
    OPT_MCCP3, TN_WILL, TN_IAC, OPT_MCCP2, TN_WILL, TN_IAC,
    OPT_SGA, TN_WONT, TN_IAC, OPT_ECHO, TN_WONT, TN_IAC,
    OPT_TTYPE, TN_DO, TN_IAC, OPT_TSPEED, TN_DO, TN_IAC
  };

  typedef enum logic [2:0] {
    PS_INPUT, PS_IAC, PS_CMD, PS_SUB, PS_SE, PS_ERROR
  } parse_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic        in_command;
    logic        error;
    logic [3:0]  flags;
    logic [15:0] tx_speed;
    logic [15:0] rx_speed;
  } result_beat_t;

  result_beat_t awaited_beats[$];
  logic [1:0]   step_kinds[$];
  logic [7:0]   step_bytes[$];

  parse_state_e ps;
  logic [7:0]   prev_rx;
  int           sub_len;
  logic [7:0]   sub_opt;
  logic         comma_seen;
  logic         text_ended;
  logic         tx_open;
  logic         rx_open;
  logic [15:0]  tx_acc;
  logic [15:0]  rx_acc;
  logic [3:0]   opt_flags;
  logic [15:0]  tx_speed;
  logic [15:0]  rx_speed;
  int           reports;
  result_beat_t got;
  result_beat_t want;

  function void put_out(input logic [1:0] kind, input logic [7:0] b);
    step_kinds.push_back(kind);
    step_bytes.push_back(b);
  endfunction

  function void put_sub_reply(input logic [7:0] opt, input logic with_send);
    put_out(KIND_REPLY, TN_IAC);
    put_out(KIND_REPLY, TN_SB);
    put_out(KIND_REPLY, opt);
    if (with_send) put_out(KIND_REPLY, TN_SB_SEND);
    put_out(KIND_REPLY, TN_IAC);
    put_out(KIND_REPLY, TN_SE);
  endfunction

  function automatic logic [15:0] shift_in_digit(input logic [15:0] acc, input logic [7:0] c);
    logic [15:0] r;
    r = acc * 16'd10 + {8'd0, c - CH_ZERO};
    return r;
  endfunction

  function void open_sub();
    sub_len    = 0;
    sub_opt    = 8'd0;
    comma_seen = 1'b0;
    text_ended = 1'b0;
    tx_acc     = 16'd0;
    rx_acc     = 16'd0;
    tx_open    = 1'b1;
    rx_open    = 1'b1;
  endfunction

  function void apply_option(input logic [7:0] opt, input logic [7:0] verb);
    case (opt)
      OPT_TSPEED, OPT_TTYPE: put_sub_reply(opt, 1'b1);
      OPT_MCCP2: begin
        if (verb == TN_DO) begin
          opt_flags[FLAG_MCCP2] = 1'b1;
          put_sub_reply(OPT_MCCP2, 1'b0);
        end
      end
      OPT_MCCP3, OPT_LINEMODE: ;
      OPT_ECHO: begin
        if (verb == TN_DO) opt_flags[FLAG_ECHO] = 1'b1;
      end
      OPT_SGA: begin
        if (verb == TN_DO) opt_flags[FLAG_SGA] = 1'b1;
        else if (verb == TN_DONT) opt_flags[FLAG_SGA] = 1'b0;
      end
      default: begin
        // Anything we do not support is refused: DO gets WONT, WILL gets DONT.
        if (verb == TN_DO || verb == TN_WILL) begin
          put_out(KIND_REPLY, TN_IAC);
          put_out(KIND_REPLY, (verb == TN_DO) ? TN_WONT : TN_DONT);
          put_out(KIND_REPLY, opt);
        end
      end
    endcase
  endfunction

  function void take_sub_byte(input logic [7:0] x);
    int idx;
    if (sub_len >= SUB_LIMIT) begin
      ps = PS_ERROR;
      return;
    end
    idx = sub_len;
    sub_len++;
    if (idx == 0) begin
      sub_opt = x;
      return;
    end
    // The speed text starts at the third byte and is cut off by the window or a NUL.
    if (idx < 2 || idx - 2 >= SPEED_WINDOW || text_ended) return;
    if (x == CH_NUL) begin
      text_ended = 1'b1;
    end else if (!comma_seen) begin
      if (x == CH_COMMA) begin
        comma_seen = 1'b1;
        tx_open    = 1'b0;
      end else if (tx_open && x >= CH_ZERO && x <= CH_NINE) begin
        tx_acc = shift_in_digit(tx_acc, x);
      end else begin
        tx_open = 1'b0;
      end
    end else begin
      if (rx_open && x >= CH_ZERO && x <= CH_NINE) rx_acc = shift_in_digit(rx_acc, x);
      else rx_open = 1'b0;
    end
  endfunction

  function void close_sub();
    if (sub_len > 0) begin
      if (sub_opt == OPT_TSPEED && comma_seen) begin
        tx_speed = tx_acc;
        rx_speed = rx_acc;
      end else if (sub_opt == OPT_MCCP3) begin
        opt_flags[FLAG_MCCP3] = 1'b1;
      end
    end
  endfunction

  function void take_rx(input logic [7:0] x, input logic full);
    case (ps)
      PS_INPUT: begin
        if (x == TN_IAC) ps = PS_IAC;
        else if (full) ps = PS_ERROR;
        else put_out(KIND_CHAR, x);
      end
      PS_IAC: begin
        if (x == TN_SB) begin
          open_sub();
          ps = PS_SUB;
        end else if (x >= TN_NOP_LO && x <= TN_NOP_HI) begin
          ps = PS_INPUT;
        end else begin
          ps = PS_CMD;
        end
      end
      PS_SUB: begin
        if (x == TN_IAC) ps = PS_SE;
        else take_sub_byte(x);
      end
      PS_SE: begin
        if (x == TN_SE) begin
          close_sub();
          ps = PS_INPUT;
        end else begin
          ps = PS_ERROR;
        end
      end
      PS_CMD: begin
        if (x <= OPT_MAX) begin
          apply_option(x, prev_rx);
          ps = PS_INPUT;
        end else begin
          ps = PS_ERROR;
        end
      end
      default: ;
    endcase
    prev_rx = x;
  endfunction

  // Works out every result beat one input beat causes and queues them in order.
  function void predict_beats(input logic start, input logic [7:0] x, input logic full);
    int k;
    result_beat_t e;
    step_kinds.delete();
    step_bytes.delete();
    if (start) begin
      for (k = 0; k < 18; k++) put_out(KIND_REPLY, CONN_PREAMBLE[k*8 +: 8]);
    end else begin
      take_rx(x, full);
    end
    if (step_kinds.size() == 0) put_out(KIND_STATUS, 8'd0);
    for (k = 0; k < step_kinds.size(); k++) begin
      e.kind       = step_kinds[k];
      e.data       = step_bytes[k];
      e.last       = (k == step_kinds.size() - 1);
      e.in_command = (ps != PS_INPUT);
      e.error      = (ps == PS_ERROR);
      e.flags      = opt_flags;
      e.tx_speed   = tx_speed;
      e.rx_speed   = rx_speed;
      awaited_beats.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ps        = PS_INPUT;
      prev_rx   = 8'd0;
      open_sub();
      opt_flags = 4'd0;
      tx_speed  = 16'd0;
      rx_speed  = 16'd0;
      awaited_beats.delete();
      fail_count = 0;
      bytes_in   = 0;
      beats_out  = 0;
      reports    = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_beats(s_tuser, s_tdata[7:0], s_tdata[8]);
        bytes_in++;
      end
      if (m_tvalid && m_tready) begin
        got.kind       = m_tuser;
        got.data       = m_tdata[7:0];
        got.last       = m_tlast;
        got.in_command = m_tdata[8];
        got.error      = m_tdata[9];
        got.flags      = m_tdata[13:10];
        got.tx_speed   = m_tdata[29:14];
        got.rx_speed   = m_tdata[45:30];
        beats_out++;
        if (awaited_beats.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS)
            $display("%0t: result beat with nothing awaited: kind %0d byte %02h last %0b",
                     $realtime, got.kind, got.data, got.last);
          reports++;
        end else begin
          want = awaited_beats.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reports < MAX_REPORTS) begin
              $display("%0t: mismatch, expected kind %0d byte %02h last %0b cmd %0b err %0b",
                       $realtime, want.kind, want.data, want.last, want.in_command, want.error);
              $display("    flags %04b tx %0d rx %0d; got kind %0d byte %02h last %0b cmd %0b",
                       want.flags, want.tx_speed, want.rx_speed, got.kind, got.data, got.last,
                       got.in_command);
              $display("    err %0b flags %04b tx %0d rx %0d",
                       got.error, got.flags, got.tx_speed, got.rx_speed);
            end
            reports++;
          end
        end
      end
    end
    awaited_count = awaited_beats.size();
  end

endmodule

@@ tb/tb_telnet_stream_option_parser_top.sv @@
// Testbench top for the telnet option parser: stimulus, flow control and the verdict.
module tb_telnet_stream_option_parser_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsop_pkg::*;

  // Values of the cmd flag carried on s_tuser.
  localparam logic RX_BYTE    = 1'b0;
  localparam logic CONN_START = 1'b1;

  localparam int RANDOM_BYTES = 200;   // input beats in the random part
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES  = 16;    // settling time once nothing is awaited

  // Ways the run finally drives the parser into its sticky error state. Error can only
  // be left by reset, so exactly one of them is picked per run, at the very end.
  typedef enum int {
    TRIP_FULL_BUFFER, TRIP_BAD_OPTION, TRIP_MISSING_SE, TRIP_SUB_OVERFLOW
  } trip_e;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // rx_byte[7:0], line_buffer_full[8], zero padding [15:9]
  logic        s_tuser;   // cmd: 0 received byte, 1 connection start
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // out_byte[7:0], in_command[8], error[9], echo_on[10], sga_on[11],
                          // mccp2_on[12], mccp3_on[13], tx_speed[29:14], rx_speed[45:30],
                          // zero padding [47:46]
  logic [1:0]  m_tuser;   // kind: 0 status, 1 character, 2 reply byte
  logic        m_tlast;

  int fail_count;
  int awaited_count;
  int bytes_in;
  int beats_out;

  // Sender bookkeeping and the handshake between the sender and the receiver process
  // for the one long hold-off.
  int         bytes_sent;
  int         conn_starts;
  bit         in_calm;
  bit         mix_preamble;
  bit         hold_req;
  bit         hold_done;
  int         idle_cycles;
  logic [7:0] sub_body[$];

  telnet_stream_option_parser_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  telnet_parser_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .bytes_in      (bytes_in),
    .beats_out     (beats_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Gap before an input beat: mostly none, often a few cycles, now and then a long one.
  // In a calm stretch the sender streams back to back.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Offers one beat and waits for the handshake. It is entered and left at a falling
  // edge, so tvalid either stays high into the next beat or is lowered for a gap, and
  // never gets two assignments in one time step.
  task automatic send_beat(input logic start, input logic [7:0] b, input logic full);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {7'd0, full, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (start) conn_starts++;
  endtask

  // Plain characters keep the buffer-full flag low; a high flag there would trip the
  // sticky error, which is saved for the end of the run.
  task automatic send_char(input logic [7:0] b);
    send_beat(RX_BYTE, b, 1'b0);
  endtask

  // A byte inside a telnet command. The buffer-full flag means nothing here, so it is
  // random. In the random part a connection start is sometimes slipped in first, which
  // lands the preamble in whatever state the parser is in.
  task automatic send_ctl(input logic [7:0] b);
    if (mix_preamble && $urandom_range(0, 99) < 3)
      send_beat(CONN_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_beat(RX_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_verb(input logic [7:0] verb, input logic [7:0] opt);
    send_ctl(TN_IAC);
    send_ctl(verb);
    send_ctl(opt);
  endtask

  // IAC SB, the bytes queued in sub_body, IAC SE.
  task automatic send_sub();
    int k;
    send_ctl(TN_IAC);
    send_ctl(TN_SB);
    for (k = 0; k < sub_body.size(); k++) send_ctl(sub_body[k]);
    send_ctl(TN_IAC);
    send_ctl(TN_SE);
  endtask

  // Stop offering and wait until every awaited result beat has come back. The wait always
  // reaches a later falling edge, so the next beat never raises tvalid in the step that lowered it.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (awaited_count != 0);
  endtask

  function automatic logic [7:0] pick_verb();
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0:       return TN_WILL;
        1:       return TN_WONT;
        2:       return TN_DO;
        default: return TN_DONT;
      endcase
    end
    // Odd verbs: anything that does not end the command after IAC, IAC itself included.
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 239));
    return 8'($urandom_range(251, 255));
  endfunction

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 9))
      0:       return OPT_ECHO;
      1:       return OPT_SGA;
      2:       return OPT_TTYPE;
      3:       return OPT_TSPEED;
      4:       return OPT_LINEMODE;
      5:       return OPT_MCCP2;
      6:       return OPT_MCCP3;
      7:       return OPT_MAX;
      default: return 8'($urandom_range(0, 140));
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Speed report body: option, the IS byte, then "tx,rx" text. Up to seven digits per
  // number so the accumulators wrap, sometimes no comma, and sometimes a NUL, junk or
  // a text long enough to run past the speed window. The body never exceeds the
  // subnegotiation limit.
  task automatic build_speed_report();
    int n;
    int k;
    int target;
    sub_body.delete();
    sub_body.push_back(OPT_TSPEED);
    sub_body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254)) : 8'd0);
    n = $urandom_range(0, 7);
    for (k = 0; k < n; k++) sub_body.push_back(pick_digit());
    if ($urandom_range(0, 9) < 8) sub_body.push_back(CH_COMMA);
    n = $urandom_range(0, 7);
    for (k = 0; k < n; k++) sub_body.push_back(pick_digit());
    case ($urandom_range(0, 5))
      0: begin
        sub_body.push_back(CH_NUL);
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) sub_body.push_back(pick_digit());
      end
      1: begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) sub_body.push_back(8'($urandom_range(0, 254)));
      end
      2: begin
        target = $urandom_range(44, 64);
        while (sub_body.size() < target)
          sub_body.push_back(($urandom_range(0, 7) == 0) ? CH_COMMA : pick_digit());
      end
      default: ;
    endcase
  endtask

  // Main stimulus process.
  initial begin
    trip_e trip;
    int    r;
    int    n;
    int    k;
    int    random_end;
    bit    drained_after_hold;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 16'd0;
    s_tuser      = RX_BYTE;
    bytes_sent   = 0;
    conn_starts  = 0;
    in_calm      = 1'b0;
    mix_preamble = 1'b0;
    hold_req     = 1'b0;
    drained_after_hold = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Preamble straight out of reset, with junk in the data field.
    send_beat(CONN_START, 8'hFF, 1'b1);
    // Plain character extremes.
    send_char(8'h00);
    send_char(8'hFE);
    // DO MCCP2 sets the flag and answers with its own subnegotiation.
    send_verb(TN_DO, OPT_MCCP2);
    // Escaped IAC: the second IAC is the verb, and the terminal-speed option still
    // draws a SEND request.
    send_verb(TN_IAC, OPT_TSPEED);
    // Empty subnegotiation, with a connection start dropped right into its middle.
    send_ctl(TN_IAC);
    send_ctl(TN_SB);
    send_beat(CONN_START, 8'h00, 1'b0);
    send_ctl(TN_IAC);
    send_ctl(TN_SE);
    // MCCP3 is switched on by a subnegotiation alone.
    sub_body.delete();
    sub_body.push_back(OPT_MCCP3);
    send_sub();
    // A short speed report: tx 9, rx 7.
    sub_body.delete();
    sub_body.push_back(OPT_TSPEED);
    sub_body.push_back(CH_NUL);
    sub_body.push_back(CH_ZERO + 8'd9);
    sub_body.push_back(CH_COMMA);
    sub_body.push_back(CH_ZERO + 8'd7);
    send_sub();
    // The sender pauses here until everything so far has come back.
    drain_results();

    // Random part: mostly well-formed telnet traffic with random content.
    mix_preamble = 1'b1;
    random_end   = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_end) begin
      if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
      // About a third of the way in, ask the receiver for its long hold-off. The sender
      // keeps offering, so the block fills up and has to stall its input.
      if (!hold_req && bytes_sent >= random_end - 2 * RANDOM_BYTES / 3) hold_req = 1'b1;
      if (hold_done && !drained_after_hold) begin
        drain_results();
        drained_after_hold = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 28) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) send_char(8'($urandom_range(0, 254)));
      end else if (r < 44) begin
        send_verb(pick_verb(), pick_option());
      end else if (r < 52) begin
        send_ctl(TN_IAC);
        send_ctl(8'($urandom_range(TN_NOP_LO, TN_NOP_HI)));
      end else if (r < 70) begin
        build_speed_report();
        send_sub();
      end else if (r < 84) begin
        sub_body.delete();
        case ($urandom_range(0, 2))
          0:       sub_body.push_back(OPT_MCCP3);
          1:       sub_body.push_back(OPT_TTYPE);
          default: sub_body.push_back(8'($urandom_range(0, 254)));
        endcase
        n = $urandom_range(0, 8);
        for (k = 0; k < n; k++) sub_body.push_back(8'($urandom_range(0, 254)));
        send_sub();
      end else if (r < 89) begin
        sub_body.delete();
        send_sub();
      end else if (r < 94) begin
        send_beat(CONN_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_verb(TN_IAC, pick_option());
      end
    end

    // Finally trip the sticky error one way, then feed it noise, preambles included,
    // which must all leave the parser where it is.
    trip = trip_e'($urandom_range(0, 3));
    case (trip)
      TRIP_FULL_BUFFER: send_beat(RX_BYTE, 8'($urandom_range(0, 254)), 1'b1);
      TRIP_BAD_OPTION:  send_verb(TN_DO, 8'($urandom_range(141, 255)));
      TRIP_MISSING_SE: begin
        send_ctl(TN_IAC);
        send_ctl(TN_SB);
        send_ctl(pick_option());
        send_ctl(TN_IAC);
        if ($urandom_range(0, 1) == 0) send_ctl(8'($urandom_range(0, 239)));
        else send_ctl(8'($urandom_range(241, 255)));
      end
      default: begin
        send_ctl(TN_IAC);
        send_ctl(TN_SB);
        for (k = 0; k < 65; k++) send_ctl(8'($urandom_range(0, 254)));
      end
    endcase
    for (k = 0; k < 15; k++)
      send_beat($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d input beats, %0d of them connection starts,", bytes_in,
             conn_starts);
    $display("and checked %0d result beats; negotiation, subnegotiations and speed %s",
             beats_out, "reports ran before sticky error was forced.");
    $display("Sticky error was entered by %s.", trip.name());
    if (fail_count == 0) begin
      $display("tb_telnet_stream_option_parser_top passed");
    end else begin
      $display("tb_telnet_stream_option_parser_top failed");
    end
    $finish;
  end

  // Receiver: random back-pressure, mostly short stalls with an occasional long one and
  // calm stretches with tready held high. The long hold-off asked for by the sender is
  // counted here in cycles.
  initial begin
    int stall_left;
    bit calm;
    m_tready   = 1'b0;
    hold_done  = 1'b0;
    stall_left = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 99) == 0) calm = !calm;
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else if (calm || $urandom_range(0, 99) < 70) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d result beats still awaited.",
               idle_cycles, awaited_count);
      $display("tb_telnet_stream_option_parser_top failed");
      $finish;
    end
  end

endmodule
